// ===== rtl/apr_pkg.sv =====
// shared types and constants of the period ring refill block
package apr_pkg;

    localparam int PERIOD_COUNT = 32;
    localparam int PERIOD_W     = $clog2(PERIOD_COUNT);
    localparam int FILL_CNT_W   = $clog2(PERIOD_COUNT + 1);

    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 8;
    localparam int POS_W        = 32;
    localparam int FRAMES_W     = 9;
    localparam int OFFSET_W     = 15;
    localparam int COUNT_W      = 32;
    localparam int CFG_INDEX_W  = 2;

    // dividend is the byte position over the bytes per frame
    localparam int DIV_W        = POS_W - 2;
    localparam int DIV_CNT_W    = $clog2(DIV_W);

    localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_PRESENT = 2'd1;

    localparam logic [STATUS_W-1:0] STS_FIFO_ERR = 8'h08;
    localparam logic [STATUS_W-1:0] STS_DESC_ERR = 8'h10;

    localparam logic [FRAMES_W-1:0] FRAMES_MIN = 9'd16;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = 9'd256;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fill_setup;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic is_service;
        logic div_last;
        logic out_free;
        logic emit_last;
    } t_dp_sts;

endpackage

// ===== rtl/apr_if.sv =====
// channel interfaces of the period ring refill block
interface apr_in_if;
    logic                              valid;
    logic                              ready;
    logic [apr_pkg::CMD_W-1:0]         cmd;
    logic [apr_pkg::STATUS_W-1:0]      stream_status;
    logic [apr_pkg::POS_W-1:0]         dma_position;
    logic                              run_seen;

    modport source (output valid, cmd, stream_status, dma_position, run_seen,
                    input ready);
    modport sink   (input valid, cmd, stream_status, dma_position, run_seen,
                    output ready);
endinterface

interface apr_out_if;
    logic                              valid;
    logic                              ready;
    logic                              fill_valid;
    logic [apr_pkg::PERIOD_W-1:0]      fill_period;
    logic [apr_pkg::OFFSET_W-1:0]      fill_offset;
    logic [apr_pkg::STATUS_W-1:0]      status_ack;
    logic                              kick;
    logic [apr_pkg::COUNT_W-1:0]       underrun_count;
    logic [apr_pkg::FILL_CNT_W-1:0]    filled_count;
    logic                              last;

    modport source (output valid, fill_valid, fill_period, fill_offset, status_ack,
                    kick, underrun_count, filled_count, last,
                    input ready);
    modport sink   (input valid, fill_valid, fill_period, fill_offset, status_ack,
                    kick, underrun_count, filled_count, last,
                    output ready);
endinterface

interface apr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [apr_pkg::CFG_INDEX_W-1:0]   index;
    logic [apr_pkg::FRAMES_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/apr_ctrl.sv =====
// sequencing state machine of the period ring refill block
module apr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  apr_pkg::t_dp_sts  i_sts,
    output apr_pkg::t_dp_cmd  o_ctl
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_SETUP = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        o_ctl.load       = 1'b0;
        o_ctl.div_step   = 1'b0;
        o_ctl.fill_setup = 1'b0;
        o_ctl.emit       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_ctl.load = 1'b1;
                    if (i_sts.is_start) begin
                        n_state = S_EMIT;
                    end else if (i_sts.is_service) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_ctl.fill_setup = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/apr_dp.sv =====
// datapath: config registers, ring state, position divider, result register
module apr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [apr_pkg::FRAMES_W-1:0]        i_cfg_data,
    input  logic [apr_pkg::CMD_W-1:0]           i_cmd,
    input  logic [apr_pkg::STATUS_W-1:0]        i_stream_status,
    input  logic [apr_pkg::POS_W-1:0]           i_dma_position,
    input  logic                                i_run_seen,
    input  apr_pkg::t_dp_cmd                    i_ctl,
    output apr_pkg::t_dp_sts                    o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_fill_valid,
    output logic [apr_pkg::PERIOD_W-1:0]        o_fill_period,
    output logic [apr_pkg::OFFSET_W-1:0]        o_fill_offset,
    output logic [apr_pkg::STATUS_W-1:0]        o_status_ack,
    output logic                                o_kick,
    output logic [apr_pkg::COUNT_W-1:0]         o_underrun_count,
    output logic [apr_pkg::FILL_CNT_W-1:0]      o_filled_count,
    output logic                                o_last
);

    localparam int PROD_W = apr_pkg::PERIOD_W + apr_pkg::FRAMES_W;

    // config registers
    logic [apr_pkg::FRAMES_W-1:0]    r_cfg_frames;
    logic                            r_device_present;

    // ring state
    logic [apr_pkg::FRAMES_W-1:0]    r_frames;
    logic [apr_pkg::PERIOD_W-1:0]    r_refill_pointer;
    logic [apr_pkg::COUNT_W-1:0]     r_underrun;
    logic                            r_running;

    // per command
    logic [apr_pkg::STATUS_W-1:0]    r_sts;
    logic                            r_kick;
    logic                            r_is_start;
    logic [apr_pkg::PERIOD_W-1:0]    r_period;
    logic [apr_pkg::FILL_CNT_W-1:0]  r_remain;
    logic [apr_pkg::FILL_CNT_W-1:0]  r_filled;

    // restoring divider
    logic [apr_pkg::DIV_W-1:0]       r_dividend;
    logic [apr_pkg::FRAMES_W-1:0]    r_rem;
    logic [apr_pkg::PERIOD_W-1:0]    r_quo;
    logic [apr_pkg::DIV_CNT_W-1:0]   r_div_cnt;

    logic                            r_out_valid;

    logic [apr_pkg::FRAMES_W-1:0]    w_clamped;
    logic [apr_pkg::FRAMES_W:0]      w_trial;
    logic [apr_pkg::FRAMES_W:0]      w_diff;
    logic                            w_ge;
    logic                            w_err;
    logic [1:0]                      w_inc;
    logic [apr_pkg::PERIOD_W-1:0]    w_span;
    logic                            w_item_fill;
    logic [PROD_W-1:0]               w_prod;
    logic                            w_start_cmd;
    logic                            w_stop_cmd;

    assign w_start_cmd = r_device_present && (i_cmd == apr_pkg::CMD_START);
    assign w_stop_cmd  = r_device_present && (i_cmd == apr_pkg::CMD_STOP);

    assign o_sts.is_start   = w_start_cmd;
    assign o_sts.is_service = r_device_present && r_running
                              && (i_cmd == apr_pkg::CMD_SERVICE);
    assign o_sts.div_last   = (r_div_cnt == apr_pkg::DIV_CNT_W'(apr_pkg::DIV_W - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.emit_last  = (r_remain <= apr_pkg::FILL_CNT_W'(1));

    always_comb begin
        if (r_cfg_frames < apr_pkg::FRAMES_MIN) begin
            w_clamped = apr_pkg::FRAMES_MIN;
        end else if (r_cfg_frames > apr_pkg::FRAMES_MAX) begin
            w_clamped = apr_pkg::FRAMES_MAX;
        end else begin
            w_clamped = r_cfg_frames;
        end
    end

    // error bit and stopped dma each count one underrun
    assign w_err = |(i_stream_status & (apr_pkg::STS_FIFO_ERR | apr_pkg::STS_DESC_ERR));
    assign w_inc = {1'b0, w_err} + {1'b0, !i_run_seen};

    assign w_trial = {r_rem, r_dividend[apr_pkg::DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_frames});
    assign w_diff  = w_trial - {1'b0, r_frames};

    assign w_span      = r_quo - r_refill_pointer;
    assign w_item_fill = (r_remain != '0);
    assign w_prod      = PROD_W'(r_period) * PROD_W'(r_frames);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_frames     <= apr_pkg::FRAMES_MIN;
            r_device_present <= 1'b0;
            r_frames         <= apr_pkg::FRAMES_MIN;
            r_refill_pointer <= '0;
            r_underrun       <= '0;
            r_running        <= 1'b0;
            r_out_valid      <= 1'b0;
            r_remain         <= '0;
            r_div_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    apr_pkg::REG_FRAMES:         r_cfg_frames     <= i_cfg_data;
                    apr_pkg::REG_DEVICE_PRESENT: r_device_present <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (i_ctl.load) begin
                if (w_start_cmd) begin
                    r_frames         <= w_clamped;
                    r_underrun       <= '0;
                    r_refill_pointer <= '0;
                    r_running        <= 1'b1;
                    r_period         <= '0;
                    r_remain         <= apr_pkg::FILL_CNT_W'(apr_pkg::PERIOD_COUNT);
                    r_filled         <= apr_pkg::FILL_CNT_W'(apr_pkg::PERIOD_COUNT);
                    r_is_start       <= 1'b1;
                    r_kick           <= 1'b1;
                    r_sts            <= '0;
                end else if (w_stop_cmd) begin
                    r_running <= 1'b0;
                end else if (o_sts.is_service) begin
                    r_underrun <= r_underrun + apr_pkg::COUNT_W'(w_inc);
                    r_is_start <= 1'b0;
                    r_kick     <= !i_run_seen;
                    r_sts      <= i_stream_status;
                    r_dividend <= i_dma_position[apr_pkg::POS_W-1:2];
                    r_rem      <= '0;
                    r_quo      <= '0;
                    r_div_cnt  <= '0;
                end
            end

            if (i_ctl.div_step) begin
                r_dividend <= {r_dividend[apr_pkg::DIV_W-2:0], 1'b0};
                r_rem      <= w_ge ? w_diff[apr_pkg::FRAMES_W-1:0]
                                   : w_trial[apr_pkg::FRAMES_W-1:0];
                r_quo      <= {r_quo[apr_pkg::PERIOD_W-2:0], w_ge};
                r_div_cnt  <= r_div_cnt + apr_pkg::DIV_CNT_W'(1);
            end

            // quotient low bits are the hardware period
            if (i_ctl.fill_setup) begin
                r_period <= r_refill_pointer;
                r_remain <= apr_pkg::FILL_CNT_W'(w_span);
                r_filled <= apr_pkg::FILL_CNT_W'(w_span);
            end

            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
                if (w_item_fill) begin
                    r_period <= r_period + apr_pkg::PERIOD_W'(1);
                    r_remain <= r_remain - apr_pkg::FILL_CNT_W'(1);
                    if (!r_is_start) begin
                        r_refill_pointer <= r_period + apr_pkg::PERIOD_W'(1);
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, payload without reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_fill_valid     <= w_item_fill;
            o_fill_period    <= w_item_fill ? r_period : '0;
            o_fill_offset    <= w_item_fill ? {w_prod[apr_pkg::OFFSET_W-3:0], 2'b00} : '0;
            o_status_ack     <= r_sts;
            o_kick           <= o_sts.emit_last && r_kick;
            o_underrun_count <= r_underrun;
            o_filled_count   <= o_sts.emit_last ? r_filled : '0;
            o_last           <= o_sts.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/audio_period_ring_refill_top.sv =====
// top level of the playback period ring refill tracker
//
// i_in carries one command item: service poll, start or stop, with the
// stream status byte, the dma byte position and the run bit seen.
// o_out carries the result items of a command, the final one flagged by
// last; underrun_count is the total after the whole command on every item.
// i_cfg writes the frames per period (index 0) and device_present (index 1);
// it is always ready; the user must see it is written only while no command
// is in flight; the block does not enforce this. start gives 32 fill items,
// one per cycle when the receiver takes them, from the emit state through
// the output register. a service poll first runs a restoring divider of the
// position by the latched period size, one quotient bit per cycle, then a
// setup step, then one item per cycle while the receiver takes them: the
// fill items from the refill pointer up to the hardware period, or a single
// empty item. stop, a poll while stopped and any command with no device
// give no item and the block is ready again the next cycle.
// a single output register holds the current item; while the receiver
// stalls the sequencer waits and no item is lost or repeated.
// reset clears ring state, underrun total, device_present; frames go to 16
module audio_period_ring_refill_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    apr_in_if.sink     i_in,
    apr_out_if.source  o_out,
    apr_cfg_if.sink    i_cfg
);

    apr_pkg::t_dp_cmd w_ctl;
    apr_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    // config writes are taken at once
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    // sequencer: idle, divide, setup, emit
    apr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // datapath with the result register facing o_out
    apr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_cmd            (i_in.cmd),
        .i_stream_status  (i_in.stream_status),
        .i_dma_position   (i_in.dma_position),
        .i_run_seen       (i_in.run_seen),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_fill_valid     (o_out.fill_valid),
        .o_fill_period    (o_out.fill_period),
        .o_fill_offset    (o_out.fill_offset),
        .o_status_ack     (o_out.status_ack),
        .o_kick           (o_out.kick),
        .o_underrun_count (o_out.underrun_count),
        .o_filled_count   (o_out.filled_count),
        .o_last           (o_out.last)
    );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the playback period ring refill tracker
`timescale 1ns / 100ps

module tb_top;

    // command code that the block must ignore
    localparam logic [apr_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
    // cycles to let pass before a register write, covers the divider and setup
    localparam int SETTLE_CYCLES = 80;
    // generous bound: every result under the longest stall, plus drains
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int TARGET_ITEMS = 470;

    // one result item as seen on the output channel
    typedef struct packed {
        logic                           fill_valid;
        logic [apr_pkg::PERIOD_W-1:0]   fill_period;
        logic [apr_pkg::OFFSET_W-1:0]   fill_offset;
        logic [apr_pkg::STATUS_W-1:0]   status_ack;
        logic                           kick;
        logic [apr_pkg::COUNT_W-1:0]    underrun_count;
        logic [apr_pkg::FILL_CNT_W-1:0] filled_count;
        logic                           last;
    } t_fill_item;

    // ring state mirror and the queue of refill items still to arrive
    class t_refill_sb;
        t_fill_item                   expected_q[$];
        int                           errors;
        logic [apr_pkg::FRAMES_W-1:0] frames_reg;
        logic                         present_reg;
        logic [apr_pkg::PERIOD_W-1:0] refill_ptr;
        logic [apr_pkg::COUNT_W-1:0]  underruns;
        logic                         running;
        int unsigned                  bytes_per_period;

        function new();
            frames_reg       = apr_pkg::FRAMES_MIN;
            present_reg      = 1'b0;
            refill_ptr       = '0;
            underruns        = '0;
            running          = 1'b0;
            bytes_per_period = 64;
            errors           = 0;
        endfunction

        function void write_reg(logic [apr_pkg::CFG_INDEX_W-1:0] idx,
                                logic [apr_pkg::FRAMES_W-1:0] data);
            if (idx == apr_pkg::REG_FRAMES)
                frames_reg = data;
            else if (idx == apr_pkg::REG_DEVICE_PRESENT)
                present_reg = data[0];
        endfunction

        function t_fill_item fill_of(logic [apr_pkg::PERIOD_W-1:0] period,
                                     logic [apr_pkg::STATUS_W-1:0] ack);
            t_fill_item item;
            item             = '0;
            item.fill_valid  = 1'b1;
            item.fill_period = period;
            item.fill_offset = apr_pkg::OFFSET_W'(32'(period) * bytes_per_period);
            item.status_ack  = ack;
            return item;
        endfunction

        // works out the refill items of one accepted command, returns their number
        function int note_command(logic [apr_pkg::CMD_W-1:0] cmd,
                                  logic [apr_pkg::STATUS_W-1:0] sts,
                                  logic [apr_pkg::POS_W-1:0] pos, logic run);
            t_fill_item                   batch[$];
            t_fill_item                   item;
            int unsigned                  frames;
            logic [apr_pkg::PERIOD_W-1:0] hw;
            logic                         kick;
            int                           filled;
            if (!present_reg)
                return 0;
            case (cmd)
                apr_pkg::CMD_START: begin
                    frames = frames_reg;
                    if (frames < apr_pkg::FRAMES_MIN) frames = apr_pkg::FRAMES_MIN;
                    if (frames > apr_pkg::FRAMES_MAX) frames = apr_pkg::FRAMES_MAX;
                    bytes_per_period = frames * 4;
                    underruns = '0;
                    for (int i = 0; i < apr_pkg::PERIOD_COUNT; i++)
                        batch.push_back(fill_of(apr_pkg::PERIOD_W'(i), '0));
                    refill_ptr = '0;
                    running = 1'b1;
                    kick = 1'b1;
                    filled = apr_pkg::PERIOD_COUNT;
                end
                apr_pkg::CMD_STOP: begin
                    running = 1'b0;
                    return 0;
                end
                apr_pkg::CMD_SERVICE: begin
                    if (!running)
                        return 0;
                    if ((sts & (apr_pkg::STS_FIFO_ERR | apr_pkg::STS_DESC_ERR)) != 0)
                        underruns++;
                    hw = apr_pkg::PERIOD_W'((pos / bytes_per_period)
                                            % apr_pkg::PERIOD_COUNT);
                    filled = 0;
                    while (refill_ptr != hw) begin
                        batch.push_back(fill_of(refill_ptr, sts));
                        refill_ptr++;
                        filled++;
                    end
                    if (batch.size() == 0) begin
                        item = '0;
                        item.status_ack = sts;
                        batch.push_back(item);
                    end
                    kick = !run;
                    if (!run)
                        underruns++;
                end
                default: return 0;
            endcase
            foreach (batch[k])
                batch[k].underrun_count = underruns;
            batch[batch.size()-1].kick         = kick;
            batch[batch.size()-1].filled_count = apr_pkg::FILL_CNT_W'(filled);
            batch[batch.size()-1].last         = 1'b1;
            foreach (batch[k])
                expected_q.push_back(batch[k]);
            return batch.size();
        endfunction

        function bit same(string field, logic [31:0] want, logic [31:0] got);
            if (want === got)
                return 1'b1;
            $display("%0t mismatch %s: expected 0x%0h actual 0x%0h",
                     $time, field, want, got);
            return 1'b0;
        endfunction

        function void check_result(t_fill_item got);
            t_fill_item want;
            bit         ok;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result item, nothing expected: %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            ok = same("fill_valid", want.fill_valid, got.fill_valid);
            ok = same("fill_period", want.fill_period, got.fill_period) & ok;
            ok = same("fill_offset", want.fill_offset, got.fill_offset) & ok;
            ok = same("status_ack", want.status_ack, got.status_ack) & ok;
            ok = same("kick", want.kick, got.kick) & ok;
            ok = same("underrun_count", want.underrun_count, got.underrun_count) & ok;
            ok = same("filled_count", want.filled_count, got.filled_count) & ok;
            ok = same("last", want.last, got.last) & ok;
            if (!ok)
                errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    apr_in_if  in_if();
    apr_out_if out_if();
    apr_cfg_if cfg_if();

    audio_period_ring_refill_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_refill_sb sb;

    // idle pressure per phase, in percent of cycles that start a gap
    int tx_gap_pct;
    int rx_stall_pct;
    // main sequence asks the receiver for one long hold-off
    bit rx_hold_req;
    // command items accepted so far
    int sent_items;
    int cycles;

    // frame counts around the clamp limits and the field extremes
    logic [apr_pkg::FRAMES_W-1:0] frame_edges [8] = '{9'd0, 9'd15, 9'd16, 9'd17,
                                                      9'd255, 9'd256, 9'd257, 9'd511};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly no gap, then short ones, a few long ones
    function automatic int rand_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one command item, note it at acceptance, then maybe go idle
    task automatic send_cmd(input logic [apr_pkg::CMD_W-1:0] cmd,
                            input logic [apr_pkg::STATUS_W-1:0] sts,
                            input logic [apr_pkg::POS_W-1:0] pos, input logic run);
        int gap;
        in_if.valid         <= 1'b1;
        in_if.cmd           <= cmd;
        in_if.stream_status <= sts;
        in_if.dma_position  <= pos;
        in_if.run_seen      <= run;
        do @(posedge i_clk); while (!in_if.ready);
        void'(sb.note_command(cmd, sts, pos, run));
        sent_items++;
        gap = rand_gap(tx_gap_pct);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the sender until every expected item is back, then let the block settle
    task automatic wait_results(input int settle);
        if (sb.expected_q.size() != 0 || settle > 0) begin
            in_if.valid <= 1'b0;
            while (sb.expected_q.size() != 0) @(posedge i_clk);
            repeat (settle) @(posedge i_clk);
        end
    endtask

    // both registers back to back on the config channel
    task automatic cfg_write(input logic [apr_pkg::FRAMES_W-1:0] frames,
                             input logic present);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= apr_pkg::REG_FRAMES;
        cfg_if.data  <= frames;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(apr_pkg::REG_FRAMES, frames);
        cfg_if.index <= apr_pkg::REG_DEVICE_PRESENT;
        cfg_if.data  <= apr_pkg::FRAMES_W'(present);
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(apr_pkg::REG_DEVICE_PRESENT, apr_pkg::FRAMES_W'(present));
        cfg_if.valid <= 1'b0;
    endtask

    // mostly polls that move the dma position a few periods past the refill pointer
    task automatic random_item(input bit lead);
        logic [apr_pkg::CMD_W-1:0]    cmd;
        logic [apr_pkg::STATUS_W-1:0] sts;
        logic [apr_pkg::POS_W-1:0]    pos;
        logic                         run;
        logic [apr_pkg::PERIOD_W-1:0] target;
        int unsigned                  pick;
        pick = $urandom_range(0, 99);
        if (lead ? pick < 85 : pick < 4)
            cmd = apr_pkg::CMD_START;
        else if (pick < 8)
            cmd = apr_pkg::CMD_STOP;
        else if (pick < 10)
            cmd = CMD_RESERVED;
        else
            cmd = apr_pkg::CMD_SERVICE;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            sts = '0;
        else if (pick < 68)
            sts = apr_pkg::STS_FIFO_ERR;
        else if (pick < 80)
            sts = apr_pkg::STS_DESC_ERR;
        else
            sts = apr_pkg::STATUS_W'($urandom());
        if ($urandom_range(0, 99) < 85)
            target = sb.refill_ptr + apr_pkg::PERIOD_W'($urandom_range(0, 8));
        else
            target = apr_pkg::PERIOD_W'($urandom_range(0, apr_pkg::PERIOD_COUNT - 1));
        if ($urandom_range(0, 99) < 80)
            pos = apr_pkg::POS_W'(($urandom_range(0, 4000) * apr_pkg::PERIOD_COUNT
                                   + target) * sb.bytes_per_period
                                  + $urandom_range(0, sb.bytes_per_period - 1));
        else
            pos = $urandom();
        run = ($urandom_range(0, 99) >= 8);
        send_cmd(cmd, sts, pos, run);
    endtask

    // run watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d items still expected",
                         cycles, sb.expected_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin : result_sink
        t_fill_item got;
        int         stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.fill_valid     = out_if.fill_valid;
                got.fill_period    = out_if.fill_period;
                got.fill_offset    = out_if.fill_offset;
                got.status_ack     = out_if.status_ack;
                got.kick           = out_if.kick;
                got.underrun_count = out_if.underrun_count;
                got.filled_count   = out_if.filled_count;
                got.last           = out_if.last;
                sb.check_result(got);
            end
            if (stall_left > 0)
                stall_left--;
            if (stall_left == 0) begin
                if (rx_hold_req) begin
                    stall_left  = LONG_HOLD;
                    rx_hold_req = 1'b0;
                end else begin
                    stall_left = rand_gap(rx_stall_pct);
                end
            end
            out_if.ready <= (stall_left == 0);
        end
    end

    initial begin : main_seq
        int phase;
        int phase_items;
        logic [apr_pkg::FRAMES_W-1:0] frames;
        sb = new();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b0;
        sent_items   = 0;
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.cmd           <= apr_pkg::CMD_SERVICE;
        in_if.stream_status <= '0;
        in_if.dma_position  <= '0;
        in_if.run_seen      <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= apr_pkg::REG_FRAMES;
        cfg_if.data         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // device absent after reset: every command is dropped
        send_cmd(apr_pkg::CMD_START, '0, '0, 1'b1);
        send_cmd(apr_pkg::CMD_SERVICE, apr_pkg::STS_FIFO_ERR | apr_pkg::STS_DESC_ERR,
                 32'd1000, 1'b0);
        send_cmd(apr_pkg::CMD_STOP, '0, '0, 1'b1);
        send_cmd(CMD_RESERVED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        wait_results(SETTLE_CYCLES);

        // frames below the minimum clamp to 16, so 64 byte periods
        cfg_write(9'd0, 1'b1);
        // poll while stopped and the reserved code give nothing
        send_cmd(apr_pkg::CMD_SERVICE, '0, 32'd500, 1'b1);
        send_cmd(CMD_RESERVED, '0, '0, 1'b0);
        send_cmd(apr_pkg::CMD_START, '0, '0, 1'b1);
        // nothing to refill: single empty item
        send_cmd(apr_pkg::CMD_SERVICE, '0, '0, 1'b1);
        send_cmd(apr_pkg::CMD_SERVICE, apr_pkg::STS_FIFO_ERR, 32'(5 * 64 + 3), 1'b1);
        // dma stopped: empty item with a re-kick and two underruns
        send_cmd(apr_pkg::CMD_SERVICE, apr_pkg::STS_DESC_ERR, 32'(5 * 64), 1'b0);
        // largest position lands on the last period
        send_cmd(apr_pkg::CMD_SERVICE, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(apr_pkg::CMD_SERVICE, apr_pkg::STS_FIFO_ERR | apr_pkg::STS_DESC_ERR,
                 32'(31 * 64 + 63), 1'b0);
        // refill wraps around the end of the ring
        send_cmd(apr_pkg::CMD_SERVICE, 8'hE7, 32'(32 * 64 * 1000 + 4 * 64), 1'b1);
        send_cmd(apr_pkg::CMD_STOP, '0, '0, 1'b1);
        send_cmd(apr_pkg::CMD_SERVICE, '0, 32'(9 * 64), 1'b1);
        wait_results(SETTLE_CYCLES);

        // frames above the maximum clamp to 256, largest offsets
        cfg_write(9'd511, 1'b1);
        send_cmd(apr_pkg::CMD_START, '0, '0, 1'b1);
        wait_results(SETTLE_CYCLES);

        // live register changes, the latched period size must not
        cfg_write(apr_pkg::FRAMES_MIN, 1'b1);
        send_cmd(apr_pkg::CMD_SERVICE, '0, 32'(10 * 1024 + 1023), 1'b1);
        send_cmd(apr_pkg::CMD_START, '0, '0, 1'b1);
        send_cmd(apr_pkg::CMD_SERVICE, apr_pkg::STS_DESC_ERR, 32'(7 * 64), 1'b0);
        wait_results(SETTLE_CYCLES);

        cfg_write(9'd257, 1'b1);
        send_cmd(apr_pkg::CMD_START, '0, '0, 1'b1);
        send_cmd(apr_pkg::CMD_SERVICE, '0, 32'h8000_0000 + 32'(3 * 1024), 1'b1);

        // random phases: new register setting each time, mostly start then polls
        phase = 0;
        while (sent_items < TARGET_ITEMS) begin
            wait_results(SETTLE_CYCLES);
            if ($urandom_range(0, 99) < 30)
                frames = frame_edges[$urandom_range(0, 7)];
            else if ($urandom_range(0, 1) == 0)
                frames = apr_pkg::FRAMES_W'($urandom_range(16, 256));
            else
                frames = apr_pkg::FRAMES_W'($urandom());
            // the long hold-off phase always runs with the device present
            cfg_write(frames, (phase == 1) || ($urandom_range(0, 9) != 0));
            // every fourth phase runs with no idling at all
            if (phase % 4 == 3) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = $urandom_range(10, 40);
                rx_stall_pct = $urandom_range(10, 50);
            end
            // receiver holds off while the sender keeps offering, the block backs up
            if (phase == 1)
                rx_hold_req = 1'b1;
            phase_items = $urandom_range(15, 45);
            for (int n = 0; n < phase_items && sent_items < TARGET_ITEMS; n++) begin
                random_item(n == 0);
                // now and then the sender waits for all results
                if ($urandom_range(0, 99) < 6)
                    wait_results(0);
            end
            phase++;
        end

        // drain and give the block time to show any stray item
        wait_results(SETTLE_CYCLES);
        if (sb.expected_q.size() != 0) begin
            $display("%0t %0d expected items never arrived", $time, sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/apr_pkg.sv
rtl/apr_if.sv
rtl/apr_ctrl.sv
rtl/apr_dp.sv
rtl/audio_period_ring_refill_top.sv
tb/tb_top.sv
